// ----- src/bsp_pkg.sv -----
// shared types, codes and constants of the bfs shortest path unit
`timescale 1ns / 1ps
package bsp_pkg;

    localparam int VW  = 7;    // vertex field width
    localparam int DSW = 6;    // distance field width
    localparam int SW  = 2;    // status field width
    localparam int AW  = 3;    // action field width
    localparam int OPW = 5;    // datapath op code width

    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_DEGREE_DEF   = 16;

    localparam logic [VW-1:0] VCOUNT_RESET = 7'd64;
    localparam logic [VW-1:0] UNREACH      = 7'h7F;

    // actions
    localparam logic [AW-1:0] ACT_CLEAR = 3'd0;
    localparam logic [AW-1:0] ACT_ADD   = 3'd1;
    localparam logic [AW-1:0] ACT_SRCH  = 3'd2;
    localparam logic [AW-1:0] ACT_QUERY = 3'd3;
    localparam logic [AW-1:0] ACT_PATH  = 3'd4;

    // result status
    localparam logic [SW-1:0] STS_OK    = 2'd0;
    localparam logic [SW-1:0] STS_RANGE = 2'd1;
    localparam logic [SW-1:0] STS_FULL  = 2'd2;

    // datapath ops
    localparam logic [OPW-1:0] OP_NONE    = 5'd0;
    localparam logic [OPW-1:0] OP_LOAD    = 5'd1;
    localparam logic [OPW-1:0] OP_DECODE  = 5'd2;
    localparam logic [OPW-1:0] OP_ADD_CHK = 5'd3;
    localparam logic [OPW-1:0] OP_ADD_WA  = 5'd4;
    localparam logic [OPW-1:0] OP_ADD_WB  = 5'd5;
    localparam logic [OPW-1:0] OP_S_INIT  = 5'd6;
    localparam logic [OPW-1:0] OP_S_POP   = 5'd7;
    localparam logic [OPW-1:0] OP_S_CUR   = 5'd8;
    localparam logic [OPW-1:0] OP_S_DEG   = 5'd9;
    localparam logic [OPW-1:0] OP_S_NB    = 5'd10;
    localparam logic [OPW-1:0] OP_S_NBD   = 5'd11;
    localparam logic [OPW-1:0] OP_S_CHK   = 5'd12;
    localparam logic [OPW-1:0] OP_Q_CHK   = 5'd13;
    localparam logic [OPW-1:0] OP_P_CHK   = 5'd14;
    localparam logic [OPW-1:0] OP_P_PUSH  = 5'd15;
    localparam logic [OPW-1:0] OP_P_PAR   = 5'd16;
    localparam logic [OPW-1:0] OP_P_OUT   = 5'd17;
    localparam logic [OPW-1:0] OP_P_EMIT  = 5'd18;
    localparam logic [OPW-1:0] OP_EMIT    = 5'd19;

    typedef struct packed {
        logic [AW-1:0] action;
        logic [VW-1:0] vertex_a;
        logic [VW-1:0] vertex_b;
    } item_t;

    typedef struct packed {
        logic [VW-1:0]  vertex;
        logic [DSW-1:0] distance;
        logic           reachable;
        logic [SW-1:0]  status;
        logic           last;
    } res_t;

    typedef struct packed {
        logic [OPW-1:0] op;
        logic           push;
    } cmd_t;

    typedef struct packed {
        logic [AW-1:0] action;
        logic          add_store;
        logic          q_empty;
        logic          nb_done;
        logic          path_go;
        logic          path_stop;
        logic          par_bad;
        logic          path_last;
        logic          out_free;
    } sts_t;

endpackage

// ----- src/bsp_ctrl.sv -----
// controller state machine of the bfs shortest path unit
`timescale 1ns / 1ps
module bsp_ctrl import bsp_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_DECODE  = 5'd1;
    localparam logic [4:0] ST_ADD_CHK = 5'd2;
    localparam logic [4:0] ST_ADD_WA  = 5'd3;
    localparam logic [4:0] ST_ADD_WB  = 5'd4;
    localparam logic [4:0] ST_S_INIT  = 5'd5;
    localparam logic [4:0] ST_S_POP   = 5'd6;
    localparam logic [4:0] ST_S_CUR   = 5'd7;
    localparam logic [4:0] ST_S_DEG   = 5'd8;
    localparam logic [4:0] ST_S_NB    = 5'd9;
    localparam logic [4:0] ST_S_NBD   = 5'd10;
    localparam logic [4:0] ST_S_CHK   = 5'd11;
    localparam logic [4:0] ST_Q_CHK   = 5'd12;
    localparam logic [4:0] ST_P_CHK   = 5'd13;
    localparam logic [4:0] ST_P_PUSH  = 5'd14;
    localparam logic [4:0] ST_P_PAR   = 5'd15;
    localparam logic [4:0] ST_P_OUT   = 5'd16;
    localparam logic [4:0] ST_P_EMIT  = 5'd17;
    localparam logic [4:0] ST_EMIT    = 5'd18;

    logic [4:0] state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.push   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.op = OP_DECODE;
                unique case (sts.action)
                    ACT_CLEAR: state_next = ST_EMIT;
                    ACT_ADD:   state_next = ST_ADD_CHK;
                    ACT_SRCH:  state_next = ST_S_INIT;
                    ACT_QUERY: state_next = ST_Q_CHK;
                    ACT_PATH:  state_next = ST_P_CHK;
                    default:   state_next = ST_IDLE;
                endcase
            end
            ST_ADD_CHK: begin
                cmd.op     = OP_ADD_CHK;
                state_next = sts.add_store ? ST_ADD_WA : ST_EMIT;
            end
            ST_ADD_WA: begin
                cmd.op     = OP_ADD_WA;
                state_next = ST_ADD_WB;
            end
            ST_ADD_WB: begin
                cmd.op     = OP_ADD_WB;
                state_next = ST_EMIT;
            end
            ST_S_INIT: begin
                cmd.op     = OP_S_INIT;
                state_next = ST_S_POP;
            end
            ST_S_POP: begin
                cmd.op     = OP_S_POP;
                state_next = sts.q_empty ? ST_EMIT : ST_S_CUR;
            end
            ST_S_CUR: begin
                cmd.op     = OP_S_CUR;
                state_next = ST_S_DEG;
            end
            ST_S_DEG: begin
                cmd.op     = OP_S_DEG;
                state_next = ST_S_NB;
            end
            ST_S_NB: begin
                cmd.op     = OP_S_NB;
                state_next = sts.nb_done ? ST_S_POP : ST_S_NBD;
            end
            ST_S_NBD: begin
                cmd.op     = OP_S_NBD;
                state_next = ST_S_CHK;
            end
            ST_S_CHK: begin
                cmd.op     = OP_S_CHK;
                state_next = ST_S_NB;
            end
            ST_Q_CHK: begin
                cmd.op     = OP_Q_CHK;
                state_next = ST_EMIT;
            end
            ST_P_CHK: begin
                cmd.op     = OP_P_CHK;
                state_next = sts.path_go ? ST_P_PUSH : ST_EMIT;
            end
            ST_P_PUSH: begin
                cmd.op     = OP_P_PUSH;
                state_next = sts.path_stop ? ST_P_OUT : ST_P_PAR;
            end
            ST_P_PAR: begin
                cmd.op     = OP_P_PAR;
                state_next = sts.par_bad ? ST_P_OUT : ST_P_PUSH;
            end
            ST_P_OUT: begin
                cmd.op     = OP_P_OUT;
                state_next = ST_P_EMIT;
            end
            ST_P_EMIT: begin
                cmd.op = OP_P_EMIT;
                if (sts.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = sts.path_last ? ST_IDLE : ST_P_OUT;
                end
            end
            ST_EMIT: begin
                cmd.op = OP_EMIT;
                if (sts.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- src/bsp_datapath.sv -----
// datapath of the bfs shortest path unit: graph memories, queue, path stack, result register
`timescale 1ns / 1ps
module bsp_datapath import bsp_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_DEGREE   = MAX_DEGREE_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [VW-1:0] cfg_wdata,
    input  item_t         s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output res_t          m_data,
    input  cmd_t          cmd,
    output sts_t          sts
);

    localparam int VI        = $clog2(MAX_VERTICES);
    localparam int QW        = $clog2(MAX_VERTICES + 1);
    localparam int DW        = $clog2(MAX_DEGREE + 1);
    localparam int NBR_DEPTH = MAX_VERTICES * MAX_DEGREE;
    localparam int NA        = $clog2(NBR_DEPTH);

    function automatic logic [NA-1:0] nbr_addr(input logic [VW-1:0] v,
                                               input logic [DW-1:0] idx);
        logic [VI-1:0] vi;
        vi       = VI'(v - VW'(1));
        nbr_addr = NA'(vi) * NA'(MAX_DEGREE) + NA'(idx);
    endfunction

    // memories
    logic [VW-1:0] nbr_mem   [NBR_DEPTH];
    logic [DW-1:0] deg_mem   [MAX_VERTICES];
    logic [VW-1:0] dist_mem  [MAX_VERTICES];
    logic [VW-1:0] par_mem   [MAX_VERTICES];
    logic [VW-1:0] queue_mem [MAX_VERTICES];
    logic [VW-1:0] stack_mem [MAX_VERTICES];

    logic [MAX_VERTICES-1:0] deg_valid_reg, deg_valid_next;
    logic [MAX_VERTICES-1:0] dist_valid_reg, dist_valid_next;

    logic [VW-1:0] nbr_q, dist_q, par_q, queue_q, stack_q;
    logic [DW-1:0] deg_a_q, deg_b_q;
    logic          deg_va_q, deg_vb_q, dist_vq;

    // control and payload registers
    logic [VW-1:0] vcount_reg;
    item_t         in_reg;
    logic [QW-1:0] head_reg, tail_reg, n_reg, k_reg;
    logic [VW-1:0] cur_reg, cur_dist_reg, nb_reg;
    logic [DW-1:0] i_reg, deg_cnt_reg, deg_a_reg, deg_b_reg;
    res_t          res_reg;
    logic          m_valid_reg;
    res_t          m_data_reg;

    // combinational
    logic [VW-1:0] cnt, deg_raddr, dist_raddr;
    logic [DW-1:0] deg_a, deg_b, deg_wdata;
    logic [VI-1:0] deg_waddr;
    logic          deg_we;
    logic [NA-1:0] nbr_waddr;
    logic [VW-1:0] nbr_wdata;
    logic          nbr_we;
    logic          a_ok, b_ok, deg_full, add_store, a_reach, nb_new;
    logic [SW-1:0] add_sts;
    logic          q_empty, nb_done;
    res_t          range_res, path_res;

    always_comb begin
        if (vcount_reg == '0)                     cnt = VW'(1);
        else if (vcount_reg > VW'(MAX_VERTICES))  cnt = VW'(MAX_VERTICES);
        else                                      cnt = vcount_reg;
        a_ok      = (in_reg.vertex_a != '0) && (in_reg.vertex_a <= cnt);
        b_ok      = (in_reg.vertex_b != '0) && (in_reg.vertex_b <= cnt);
        deg_a     = deg_va_q ? deg_a_q : '0;
        deg_b     = deg_vb_q ? deg_b_q : '0;
        deg_full  = (deg_a >= DW'(MAX_DEGREE)) || (deg_b >= DW'(MAX_DEGREE));
        add_store = a_ok && b_ok && (in_reg.vertex_a < in_reg.vertex_b) && !deg_full;
        if (!(a_ok && b_ok))                          add_sts = STS_RANGE;
        else if (in_reg.vertex_a >= in_reg.vertex_b)  add_sts = STS_OK;
        else if (deg_full)                            add_sts = STS_FULL;
        else                                          add_sts = STS_OK;
        a_reach = dist_vq && (dist_q != UNREACH);
        nb_new  = (nb_reg != '0) && (nb_reg <= cnt) && !a_reach;
        q_empty = (head_reg >= tail_reg) || (head_reg >= QW'(MAX_VERTICES));
        nb_done = (i_reg >= deg_cnt_reg);

        range_res = '{vertex: in_reg.vertex_a, distance: '0, reachable: 1'b0,
                      status: STS_RANGE, last: 1'b1};
        path_res  = '{vertex: stack_q, distance: DSW'(k_reg), reachable: 1'b1,
                      status: STS_OK, last: ((k_reg + QW'(1)) == n_reg)};

        // read addresses
        deg_raddr  = (cmd.op == OP_S_CUR) ? queue_q : in_reg.vertex_a;
        if (cmd.op == OP_S_CUR)       dist_raddr = queue_q;
        else if (cmd.op == OP_S_NBD)  dist_raddr = nbr_q;
        else                          dist_raddr = in_reg.vertex_a;

        // edge writes, one endpoint a cycle
        deg_we    = (cmd.op == OP_ADD_WA) || (cmd.op == OP_ADD_WB);
        nbr_we    = deg_we;
        if (cmd.op == OP_ADD_WB) begin
            deg_waddr = VI'(in_reg.vertex_b - VW'(1));
            deg_wdata = deg_b_reg + DW'(1);
            nbr_waddr = nbr_addr(in_reg.vertex_b, deg_b_reg);
            nbr_wdata = in_reg.vertex_a;
        end else begin
            deg_waddr = VI'(in_reg.vertex_a - VW'(1));
            deg_wdata = deg_a_reg + DW'(1);
            nbr_waddr = nbr_addr(in_reg.vertex_a, deg_a_reg);
            nbr_wdata = in_reg.vertex_b;
        end

        deg_valid_next  = deg_valid_reg;
        dist_valid_next = dist_valid_reg;
        if ((cmd.op == OP_DECODE) && (in_reg.action == ACT_CLEAR)) begin
            deg_valid_next  = '0;
            dist_valid_next = '0;
        end
        if (deg_we) deg_valid_next[deg_waddr] = 1'b1;
        if (cmd.op == OP_S_INIT) begin
            dist_valid_next    = '0;
            dist_valid_next[0] = 1'b1;
        end
        if ((cmd.op == OP_S_CHK) && nb_new) dist_valid_next[VI'(nb_reg - VW'(1))] = 1'b1;

        sts.action    = in_reg.action;
        sts.add_store = add_store;
        sts.q_empty   = q_empty;
        sts.nb_done   = nb_done;
        sts.path_go   = a_ok && a_reach;
        sts.path_stop = (cur_reg == VW'(1)) || ((n_reg + QW'(1)) >= QW'(MAX_VERTICES));
        sts.par_bad   = (par_q == '0) || (par_q > VW'(MAX_VERTICES));
        sts.path_last = ((k_reg + QW'(1)) == n_reg);
        sts.out_free  = !m_valid_reg || m_ready;
    end

    // memories, registered reads
    always_ff @(posedge aclk) begin
        if (nbr_we) nbr_mem[nbr_waddr] <= nbr_wdata;
        nbr_q <= nbr_mem[nbr_addr(cur_reg, i_reg)];
    end

    always_ff @(posedge aclk) begin
        if (deg_we) deg_mem[deg_waddr] <= deg_wdata;
        deg_a_q  <= deg_mem[VI'(deg_raddr - VW'(1))];
        deg_b_q  <= deg_mem[VI'(in_reg.vertex_b - VW'(1))];
        deg_va_q <= deg_valid_reg[VI'(deg_raddr - VW'(1))];
        deg_vb_q <= deg_valid_reg[VI'(in_reg.vertex_b - VW'(1))];
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_S_INIT) begin
            dist_mem[0] <= '0;
        end else if ((cmd.op == OP_S_CHK) && nb_new) begin
            dist_mem[VI'(nb_reg - VW'(1))] <= cur_dist_reg + VW'(1);
        end
        dist_q  <= dist_mem[VI'(dist_raddr - VW'(1))];
        dist_vq <= dist_valid_reg[VI'(dist_raddr - VW'(1))];
    end

    always_ff @(posedge aclk) begin
        if ((cmd.op == OP_S_CHK) && nb_new) par_mem[VI'(nb_reg - VW'(1))] <= cur_reg;
        par_q <= par_mem[VI'(cur_reg - VW'(1))];
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_S_INIT) begin
            queue_mem[0] <= VW'(1);
        end else if ((cmd.op == OP_S_CHK) && nb_new && (tail_reg < QW'(MAX_VERTICES))) begin
            queue_mem[tail_reg[VI-1:0]] <= nb_reg;
        end
        queue_q <= queue_mem[head_reg[VI-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_P_PUSH) stack_mem[n_reg[VI-1:0]] <= cur_reg;
        stack_q <= stack_mem[VI'(n_reg - k_reg - QW'(1))];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg     <= VCOUNT_RESET;
            deg_valid_reg  <= '0;
            dist_valid_reg <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) vcount_reg <= cfg_wdata;
            deg_valid_reg  <= deg_valid_next;
            dist_valid_reg <= dist_valid_next;
            if (cmd.op == OP_S_INIT) begin
                head_reg <= '0;
                tail_reg <= QW'(1);
            end else if ((cmd.op == OP_S_POP) && !q_empty) begin
                head_reg <= head_reg + QW'(1);
            end else if ((cmd.op == OP_S_CHK) && nb_new && (tail_reg < QW'(MAX_VERTICES))) begin
                tail_reg <= tail_reg + QW'(1);
            end
            if (cmd.push)     m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LOAD) in_reg <= s_data;
        if (cmd.push) m_data_reg <= (cmd.op == OP_P_EMIT) ? path_res : res_reg;
        unique case (cmd.op)
            OP_DECODE: begin
                res_reg <= '{vertex: '0, distance: '0, reachable: 1'b0,
                             status: STS_OK, last: 1'b1};
            end
            OP_ADD_CHK: begin
                deg_a_reg <= deg_a;
                deg_b_reg <= deg_b;
                res_reg   <= '{vertex: in_reg.vertex_a, distance: '0, reachable: 1'b0,
                               status: add_sts, last: 1'b1};
            end
            OP_S_POP: begin
                res_reg <= '{vertex: VW'(1), distance: '0, reachable: 1'b1,
                             status: STS_OK, last: 1'b1};
            end
            OP_S_CUR: cur_reg <= queue_q;
            OP_S_DEG: begin
                deg_cnt_reg  <= (deg_a > DW'(MAX_DEGREE)) ? DW'(MAX_DEGREE) : deg_a;
                cur_dist_reg <= dist_q;
                i_reg        <= '0;
            end
            OP_S_NB: if (!nb_done) i_reg <= i_reg + DW'(1);
            OP_S_NBD: nb_reg <= nbr_q;
            OP_Q_CHK: begin
                res_reg <= !a_ok ? range_res :
                           res_t'{vertex: in_reg.vertex_a,
                                  distance: a_reach ? dist_q[DSW-1:0] : '0,
                                  reachable: a_reach, status: STS_OK, last: 1'b1};
            end
            OP_P_CHK: begin
                res_reg <= !a_ok ? range_res :
                           res_t'{vertex: in_reg.vertex_a, distance: '0, reachable: 1'b0,
                                  status: STS_OK, last: 1'b1};
                cur_reg <= in_reg.vertex_a;
                n_reg   <= '0;
                k_reg   <= '0;
            end
            OP_P_PUSH: n_reg <= n_reg + QW'(1);
            OP_P_PAR: if (!sts.par_bad) cur_reg <= par_q;
            OP_P_EMIT: if (cmd.push) k_reg <= k_reg + QW'(1);
            default: ;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- src/bfs_shortest_path_unit.sv -----
// top level of the bfs shortest path unit: controller, datapath and checks
//
//  channel  ports                      payload   accepted when
//  input    s_valid s_ready s_data     item_t    s_valid && s_ready
//  result   m_valid m_ready m_data     res_t     m_valid && m_ready
//  config   cfg_we cfg_wdata           7 bits    cfg_we
//
//  one word at a time; the next input word is taken as soon as the state machine is
//  back in idle, even while the last result word still waits in the output register.
//  clear: decode, then emit. query: decode, check, emit. add edge: decode, check,
//  then the writes of endpoint a and endpoint b when the edge is stored, then emit.
//  search: pops each queued vertex and walks its neighbor and distance entries one
//  at a time. path: walks parents back to vertex 1, then emits the stacked words.
//  reset clears valid bits of degree and distance stores at once, no clearing pass.
//  a stalled result channel holds the machine in its emit state.
`timescale 1ns / 1ps
module bfs_shortest_path_unit import bsp_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_DEGREE   = MAX_DEGREE_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [VW-1:0] cfg_wdata,
    input  logic          s_valid,
    output logic          s_ready,
    input  item_t         s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output res_t          m_data
);

    // command and status between the state machine and the datapath
    cmd_t cmd;
    sts_t sts;

    bsp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bsp_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .sts       (sts)
    );

    // a result word is only loaded into a free output register
    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> sts.out_free)
        else $error("result pushed into a busy output register");

    // no result is produced while the machine waits for input
    a_idle_no_push: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !cmd.push)
        else $error("result pushed while idle");

    // output register is empty after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule
